// ----- sv/u16u8_pkg.sv -----
// Shared types, constants and encoding helpers for the UTF-16/UTF-32 to UTF-8 transcoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package u16u8_pkg;

    // One input item: a wide code unit and the end-of-string marker.
    typedef struct packed {
        logic [31:0] code_unit;
        logic        last_unit;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
        logic       encode_error;
    } t_out_item;

    // Classified work item that travels from the front end to the byte serializer.
    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  len_m1;
        logic        is_status;
        logic        last_unit;
    } t_cmd;

    // Encoded length codes (number of bytes minus one).
    localparam logic [1:0] LEN_1B = 2'd0;
    localparam logic [1:0] LEN_2B = 2'd1;
    localparam logic [1:0] LEN_3B = 2'd2;
    localparam logic [1:0] LEN_4B = 2'd3;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [31:0] MAX_CODE_POINT  = 32'h0010_FFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h01_0000;
    localparam logic [20:0] MAX_1B          = 21'h00_007F;
    localparam logic [20:0] MAX_2B          = 21'h00_07FF;
    localparam logic [20:0] MAX_3B          = 21'h00_FFFF;

    function automatic logic [1:0] cp_len(input logic [20:0] cp);
        logic [1:0] len;
        if (cp <= MAX_1B) begin
            len = LEN_1B;
        end else if (cp <= MAX_2B) begin
            len = LEN_2B;
        end else if (cp <= MAX_3B) begin
            len = LEN_3B;
        end else begin
            len = LEN_4B;
        end
        return len;
    endfunction

    // Byte number idx (0 = lead byte) of the UTF-8 sequence for cp.
    function automatic logic [7:0] encode_byte(input logic [20:0] cp, input logic [1:0] len,
                                               input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_1B: b = {1'b0, cp[6:0]};
            LEN_2B: begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            LEN_3B: begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_4B: begin
                unique case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- sv/u16u8_front.sv -----
// Front end: accepts code units, validates and pairs surrogates, and issues work items.
// Depends on u16u8_pkg; feeds u16u8_queue.
`default_nettype none

module u16u8_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire u16u8_pkg::t_in_item i_in_item,
    input  wire logic               i_full,
    output logic                    o_push,
    output u16u8_pkg::t_cmd         o_cmd
);
    import u16u8_pkg::*;

    logic       r_mode;
    logic       r_pending;
    logic [9:0] r_hi;
    logic       r_drop;
    logic       n_pending;
    logic [9:0] n_hi;
    logic       n_drop;

    logic        accept;
    logic        last;
    logic [15:0] u16;
    logic        do_fail;
    logic        do_emit;
    logic [20:0] cp;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign last       = i_in_item.last_unit;
    assign u16        = i_in_item.code_unit[15:0];

    always_comb begin
        do_fail   = 1'b0;
        do_emit   = 1'b0;
        cp        = '0;
        n_pending = r_pending;
        n_hi      = r_hi;
        n_drop    = r_drop;

        priority if (r_drop) begin
            do_fail = last;
        end else if (r_mode) begin
            if (r_pending || (i_in_item.code_unit > MAX_CODE_POINT)
                || ((u16 >= HIGH_SURR_FIRST) && (u16 <= LOW_SURR_LAST)
                    && (i_in_item.code_unit[31:16] == 16'h0000))) begin
                do_fail = 1'b1;
            end else begin
                do_emit = 1'b1;
                cp      = i_in_item.code_unit[20:0];
            end
        end else if (r_pending) begin
            if ((u16 < LOW_SURR_FIRST) || (u16 > LOW_SURR_LAST)) begin
                do_fail = 1'b1;
            end else begin
                do_emit   = 1'b1;
                cp        = SUPP_BASE + {1'b0, r_hi, u16[9:0]};
                n_pending = 1'b0;
                n_hi      = '0;
            end
        end else if ((u16 >= HIGH_SURR_FIRST) && (u16 <= HIGH_SURR_LAST)) begin
            if (last) begin
                do_fail = 1'b1;
            end else begin
                n_pending = 1'b1;
                n_hi      = u16[9:0];
            end
        end else if ((u16 >= LOW_SURR_FIRST) && (u16 <= LOW_SURR_LAST)) begin
            do_fail = 1'b1;
        end else begin
            do_emit = 1'b1;
            cp      = {5'd0, u16};
        end

        if (do_fail) begin
            n_pending = 1'b0;
            n_hi      = '0;
            n_drop    = !last;
        end
    end

    assign o_push = accept && (do_fail || do_emit);

    always_comb begin
        o_cmd.code_point = do_fail ? 21'd0 : cp;
        o_cmd.len_m1     = do_fail ? LEN_1B : cp_len(cp);
        o_cmd.is_status  = do_fail;
        o_cmd.last_unit  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_pending <= 1'b0;
            r_hi      <= '0;
            r_drop    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pending <= n_pending;
                r_hi      <= n_hi;
                r_drop    <= n_drop;
            end
        end
    end

    // A held surrogate and the drop state exclude each other.
    a_pend_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending && r_drop))
        else $error("surrogate held while dropping");

    // A last unit always leaves the front end with no string state.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (!r_pending && !r_drop))
        else $error("string state survived the last unit");

endmodule

`default_nettype wire

// ----- sv/u16u8_queue.sv -----
// Small register queue that decouples the front end from the byte serializer.
// Depends on u16u8_pkg for the work item type.
`default_nettype none

module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u16u8_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output u16u8_pkg::t_cmd     o_head
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_valid))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- sv/u16u8_back.sv -----
// Back end: serializes each queued work item into UTF-8 byte or status results.
// Depends on u16u8_pkg; reads from u16u8_queue and drives the output register.
`default_nettype none

module u16u8_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire u16u8_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output u16u8_pkg::t_out_item o_out_item
);
    import u16u8_pkg::*;

    logic      r_out_valid;
    t_out_item r_out;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    t_out_item n_out;
    logic      load;
    logic      take;
    logic      fin;

    assign load = !r_out_valid || !i_out_stall;
    assign take = load && i_head_valid;
    assign fin  = i_head.is_status || (r_idx == i_head.len_m1);
    assign o_pop = take && fin;
    assign n_idx = fin ? 2'd0 : r_idx + 2'd1;

    always_comb begin
        if (i_head.is_status) begin
            n_out.data_byte    = 8'h00;
            n_out.byte_valid   = 1'b0;
            n_out.run_last     = 1'b1;
            n_out.string_done  = i_head.last_unit;
            n_out.encode_error = 1'b1;
        end else begin
            n_out.data_byte    = encode_byte(i_head.code_point, i_head.len_m1, r_idx);
            n_out.byte_valid   = 1'b1;
            n_out.run_last     = fin;
            n_out.string_done  = fin && i_head.last_unit;
            n_out.encode_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= i_head_valid;
            end
            if (take) begin
                r_idx <= n_idx;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A partly sent sequence keeps its work item at the head of the queue.
    a_idx_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_head_valid)
        else $error("byte index advanced without a queued item");

    // Status results carry no byte and always close their run.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.encode_error) |-> (!r_out.byte_valid && r_out.run_last))
        else $error("malformed status result");

endmodule

`default_nettype wire

// ----- sv/utf16_to_utf8_transcoder_top.sv -----
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) carries one code unit per
//   transfer with a flag on the last unit of a string. Output channel (o_out_valid,
//   i_out_stall, o_out_item) carries one UTF-8 byte or one status result per transfer.
//   The single configuration bit selects UTF-16 (0) or UTF-32 (1) units; it must be written
//   through i_cfg_wr_en / i_cfg_wr_data only while the block is idle; the block does not enforce this.
// A unit's work item is registered in the queue, and its first result then in the output register.
// Throughput: one code unit per cycle while each unit yields at most one result and i_out_stall is low.
//   A unit that encodes to N bytes yields one result per byte in turn, so the sustained
//   rate is one result per cycle while the output is not stalled, set by the single output register.
//   High surrogates and units dropped after an error, the last unit of a string apart,
//   yield no result and take no queue entry.
// The queue between front end and serializer holds QUEUE_DEPTH work items; the
//   input stalls only when it is full.
// Reset (synchronous, active low) clears the mode bit to UTF-16, drops any held
//   surrogate and error state, and empties the queue and output register.
// When the receiver stalls, the presented result holds and the queue fills; the
//   input keeps taking units until the queue is full.
`default_nettype none

module utf16_to_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire u16u8_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output u16u8_pkg::t_out_item     o_out_item
);
    import u16u8_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    t_cmd head;

    // Front end: validation, surrogate pairing and error tracking per string.
    u16u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_full        (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Work item queue, so that a stalled output does not stop the input at once.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back end: one byte or status result per cycle into the output register while the output is not stalled.
    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

    // A byte result never carries the error flag.
    a_byte_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.byte_valid) |-> !o_out_item.encode_error)
        else $error("byte result flagged as error");

endmodule

`default_nettype wire
